### rtl/core/gbns_pkg.sv
// shared types and constants of the go-back-n sender window
`timescale 1ns / 1ps

package gbns_pkg;

   // payload field widths
   localparam int OP_W          = 2;
   localparam int ACK_NUMBER_W  = 32;
   localparam int MAC_W         = 48;
   localparam int FRAME_INDEX_W = 10;
   localparam int SEQ_W         = 11;
   localparam int TOTAL_W       = 11;

   // widest frame index that a command can carry
   localparam int CMD_INDEX_W   = 16;

   // control register file
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 48;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL_FRAMES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_MAC     = 1'd1;

   // reset values and fixed offsets
   localparam logic [MAC_W-1:0] PEER_MAC_RESET = 48'h142D_27D6_C58F;
   localparam logic [SEQ_W-1:0] SEQ_OFFSET     = 11'd1000;

   // request opcodes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // commands handed from the front end to the back end
   typedef enum logic [1:0] {
      CMD_START,
      CMD_ACK,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [CMD_INDEX_W-1:0] index;
   } cmd_type;

   // back end status seen by the front end
   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

### rtl/core/gbns_req_if.sv
// request channel carrying start, ack and tick words
`timescale 1ns / 1ps

interface gbns_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [gbns_pkg::OP_W-1:0]             op;
   logic [gbns_pkg::ACK_NUMBER_W-1:0]     ack_number;
   logic [gbns_pkg::MAC_W-1:0]            source_mac;

   modport source (output valid, output op, output ack_number, output source_mac,
                   input ready);
   modport sink (input valid, input op, input ack_number, input source_mac,
                 output ready);
endinterface

### rtl/core/gbns_rsp_if.sv
// response channel carrying frames to transmit
`timescale 1ns / 1ps

interface gbns_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [gbns_pkg::FRAME_INDEX_W-1:0]    frame_index;
   logic [gbns_pkg::SEQ_W-1:0]            tcp_sequence;
   logic                                  last;

   modport source (output valid, output frame_index, output tcp_sequence, output last,
                   input ready);
   modport sink (input valid, input frame_index, input tcp_sequence, input last,
                 output ready);
endinterface

### rtl/core/gbns_csr_if.sv
// control register write channel
`timescale 1ns / 1ps

interface gbns_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [gbns_pkg::CSR_INDEX_W-1:0]      index;
   logic [gbns_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/gbns_cmd_fifo.sv
// two-entry command queue between front end and back end
`timescale 1ns / 1ps

module gbns_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gbns_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gbns_pkg::cmd_type pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gbns_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/gbns_front.sv
// front end: accepts request words and turns them into commands
`timescale 1ns / 1ps

module gbns_front #(
   parameter int TOT_W = 11
) (
   gbns_req_if.sink                      req_if,
   input  logic [gbns_pkg::MAC_W-1:0]    peer_mac,
   input  logic [TOT_W-1:0]              eff_total,
   input  gbns_pkg::status_type          status,
   output logic                          push_valid,
   input  logic                          push_ready,
   output gbns_pkg::cmd_type             push_data
);

   localparam int ACK_W = gbns_pkg::ACK_NUMBER_W;
   localparam int IDX_W = gbns_pkg::CMD_INDEX_W;

   logic accept;
   logic keep;
   logic ack_ok;

   // no words taken while the ack map is being cleared
   assign req_if.ready = push_ready && !status.clearing;
   assign accept       = req_if.valid && req_if.ready;

   // ack from the peer, numbered 1 to the frame total
   assign ack_ok = (req_if.source_mac == peer_mac) &&
                   (req_if.ack_number != '0) &&
                   (req_if.ack_number <= ACK_W'(eff_total));

   // classify the word
   always_comb begin
      push_data.kind  = gbns_pkg::CMD_TICK;
      push_data.index = IDX_W'(req_if.ack_number - ACK_W'(1));
      keep            = 1'b0;
      case (req_if.op)
         gbns_pkg::OP_START: begin
            push_data.kind = gbns_pkg::CMD_START;
            keep           = 1'b1;
         end
         gbns_pkg::OP_ACK: begin
            push_data.kind = gbns_pkg::CMD_ACK;
            keep           = ack_ok;
         end
         gbns_pkg::OP_TICK: begin
            push_data.kind = gbns_pkg::CMD_TICK;
            keep           = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // dropped words are accepted but never queued
   assign push_valid = accept && keep;

endmodule

### rtl/core/gbns_back.sv
// back end: ack map, window base and frame burst sequencer
`timescale 1ns / 1ps

module gbns_back #(
   parameter int MAX_FRAMES = 1024,
   parameter int WINDOW     = 5,
   parameter int TOT_W      = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TOT_W-1:0]     eff_total,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  gbns_pkg::cmd_type    pop_data,
   output gbns_pkg::status_type status,
   gbns_rsp_if.source           rsp_if
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int LIM_W = TOT_W + 1;
   localparam int FI_W  = gbns_pkg::FRAME_INDEX_W;
   localparam int SQ_W  = gbns_pkg::SEQ_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TICK,
      ST_BURST
   } state_type;

   state_type           state_ff, state_in;
   logic [TOT_W-1:0]    base_ff, base_in;
   logic [TOT_W-1:0]    ptr_ff, ptr_in;
   logic [LIM_W-1:0]    emit_lim_ff, emit_lim_in;
   logic [LIM_W-1:0]    walk_lim_ff, walk_lim_in;
   logic                clear_ff, clear_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TOT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;

   // ack map, one bit per frame
   logic                acked_mem [MAX_FRAMES];
   logic                rd_bit_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic                mem_wdata;

   logic                out_free;
   logic [LIM_W-1:0]    base_ext, tot_ext, max_ext, win_ext, ptr_ext;
   logic [LIM_W-1:0]    base_win;
   logic [LIM_W-1:0]    start_lim;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign base_ext  = LIM_W'(base_ff);
   assign tot_ext   = LIM_W'(eff_total);
   assign max_ext   = LIM_W'(MAX_FRAMES);
   assign win_ext   = LIM_W'(WINDOW);
   assign ptr_ext   = LIM_W'(ptr_ff);
   assign base_win  = base_ext + win_ext;
   assign start_lim = (win_ext < tot_ext) ? win_ext : tot_ext;

   assign pop_ready       = (state_ff == ST_IDLE);
   assign status.clearing = (state_ff == ST_CLEAR);

   // sequencer next state, memory write port and output register
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      emit_lim_in  = emit_lim_ff;
      walk_lim_in  = walk_lim_ff;
      clear_in     = clear_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[IDX_W-1:0];
      mem_wdata    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == TOT_W'(MAX_FRAMES - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + TOT_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_data.kind)
                  gbns_pkg::CMD_START: begin
                     base_in     = '0;
                     ptr_in      = '0;
                     emit_lim_in = start_lim;
                     walk_lim_in = start_lim;
                     clear_in    = 1'b0;
                     if (start_lim != '0) begin
                        state_in = ST_BURST;
                     end
                  end
                  gbns_pkg::CMD_ACK: begin
                     mem_we    = 1'b1;
                     mem_waddr = pop_data.index[IDX_W-1:0];
                     mem_wdata = 1'b1;
                  end
                  gbns_pkg::CMD_TICK: begin
                     // map bit of the base is read on this edge
                     if (base_ff < eff_total) begin
                        state_in = ST_TICK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (rd_bit_ff) begin
               // base acked: slide by one, expose the next frame
               if (base_win < tot_ext) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = TOT_W'(base_win);
                     rsp_last_in  = 1'b1;
                     base_in      = base_ff + TOT_W'(1);
                     state_in     = ST_IDLE;
                  end
               end else begin
                  base_in  = base_ff + TOT_W'(1);
                  state_in = ST_IDLE;
               end
            end else begin
               // go back: clear and resend the whole window
               ptr_in      = base_ff;
               emit_lim_in = (base_win < tot_ext) ? base_win : tot_ext;
               walk_lim_in = (base_win < max_ext) ? base_win : max_ext;
               clear_in    = 1'b1;
               state_in    = ST_BURST;
            end
         end
         ST_BURST: begin
            if (out_free) begin
               mem_we = clear_ff;
               if (ptr_ext < emit_lim_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = ptr_ff;
                  rsp_last_in  = (ptr_ext + LIM_W'(1) == emit_lim_ff);
               end
               ptr_in = ptr_ff + TOT_W'(1);
               if (ptr_ext + LIM_W'(1) == walk_lim_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         ptr_ff       <= '0;
         emit_lim_ff  <= '0;
         walk_lim_ff  <= '0;
         clear_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         ptr_ff       <= ptr_in;
         emit_lim_ff  <= emit_lim_in;
         walk_lim_ff  <= walk_lim_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ack map write and registered read of the base bit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         acked_mem[mem_waddr] <= mem_wdata;
      end
      rd_bit_ff <= acked_mem[base_ff[IDX_W-1:0]];
   end

   // response word
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_index  = FI_W'(rsp_index_ff);
   assign rsp_if.tcp_sequence = SQ_W'(rsp_index_ff) + gbns_pkg::SEQ_OFFSET;
   assign rsp_if.last         = rsp_last_ff;

endmodule

### rtl/core/go_back_n_sender_window.sv
// Go-back-N sender window. A start word rewinds the base to frame 0 and sends the first
// window; an ack word from the peer MAC marks its frame in the ack map; a tick word slides
// past an acked base (sending base plus WINDOW if it exists) or clears the window marks and
// resends the window. Request words are taken by the front end and queued; an ack writes
// its map bit, a tick first reads the base bit from the registered map read and then slides
// or resends, and bursts leave at one frame per cycle while the receiver is ready, through
// the single response register. After reset the ack map is swept clear, during which no
// request word is taken; register writes are taken at any time.
`timescale 1ns / 1ps

module go_back_n_sender_window #(
   parameter int MAX_FRAMES = 1024,
   parameter int WINDOW     = 5
) (
   input  logic          clock,
   input  logic          reset,
   gbns_req_if.sink      req_if,
   gbns_rsp_if.source    rsp_if,
   gbns_csr_if.sink      csr_if
);

   localparam int IDX_W   = $clog2(MAX_FRAMES);
   localparam int TOT_W   = (IDX_W + 1 > gbns_pkg::TOTAL_W) ? IDX_W + 1 : gbns_pkg::TOTAL_W;
   localparam int TF_W    = gbns_pkg::TOTAL_W;
   localparam int MAC_W   = gbns_pkg::MAC_W;

   logic [TF_W-1:0]        total_frames_ff, total_frames_in;
   logic [MAC_W-1:0]       peer_mac_ff, peer_mac_in;
   logic [TOT_W-1:0]       eff_total;
   logic                   csr_write;
   logic                   push_valid, push_ready;
   gbns_pkg::cmd_type      push_data;
   logic                   pop_valid, pop_ready;
   gbns_pkg::cmd_type      pop_data;
   gbns_pkg::status_type   status;

   // register writes
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   always_comb begin
      total_frames_in = total_frames_ff;
      peer_mac_in     = peer_mac_ff;
      if (csr_write) begin
         case (csr_if.index)
            gbns_pkg::REG_TOTAL_FRAMES: total_frames_in = TF_W'(csr_if.data);
            gbns_pkg::REG_PEER_MAC:     peer_mac_in     = MAC_W'(csr_if.data);
            default: begin
               total_frames_in = total_frames_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_frames_ff <= '0;
         peer_mac_ff     <= gbns_pkg::PEER_MAC_RESET;
      end else begin
         total_frames_ff <= total_frames_in;
         peer_mac_ff     <= peer_mac_in;
      end
   end

   // frame total limited to the map depth
   assign eff_total = (TOT_W'(total_frames_ff) > TOT_W'(MAX_FRAMES)) ?
                      TOT_W'(MAX_FRAMES) : TOT_W'(total_frames_ff);

   gbns_front #(
      .TOT_W (TOT_W)
   ) u_front (
      .req_if     (req_if),
      .peer_mac   (peer_mac_ff),
      .eff_total  (eff_total),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   gbns_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gbns_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .WINDOW     (WINDOW),
      .TOT_W      (TOT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_total  (eff_total),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (status),
      .rsp_if     (rsp_if)
   );

endmodule
